/* src/tmcr_pkg.sv */
// Shared constants for the tiled midpoint circle rasterizer.
// No dependencies; every other file refers to names here by tmcr_pkg:: scope.
package tmcr_pkg;

  // Tile geometry: 8x8 pixels, one mask bit per pixel.
  localparam int unsigned TILE_SIDE = 8;
  localparam int unsigned TILE_BITS = $clog2(TILE_SIDE);
  localparam int unsigned MASK_W    = TILE_SIDE * TILE_SIDE;

  // Default screen coordinate width.
  localparam int unsigned COORD_BITS_DEF = 12;

  // Width of one queued command as laid out by the front end:
  // {overlap, radius, ty_lo, tx_lo, ry, rx}.
  function automatic int unsigned entry_width(input int unsigned coord_bits);
    return 2 * (coord_bits + 1) + 2 * TILE_BITS + (coord_bits - 1) + 1;
  endfunction

endpackage

/* src/tmcr_front.sv */
// Front end: takes a circle command, makes it tile-relative, runs the box test.
// Depends on tmcr_pkg; feeds tmcr_queue.
module tmcr_front #(
  parameter int unsigned COORD_BITS = tmcr_pkg::COORD_BITS_DEF,
  parameter int unsigned ENTRY_W    = tmcr_pkg::entry_width(COORD_BITS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [COORD_BITS-1:0] center_x_i,
  input  logic signed [COORD_BITS-1:0] center_y_i,
  input  logic        [COORD_BITS-2:0] radius_i,
  input  logic signed [COORD_BITS-1:0] tile_x_i,
  input  logic signed [COORD_BITS-1:0] tile_y_i,
  output logic                         busy_o,
  output logic                         push_o,
  output logic [ENTRY_W-1:0]           entry_o,
  input  logic                         full_i
);

  localparam int unsigned RW = COORD_BITS + 1;  // relative offset width
  localparam int unsigned PW = COORD_BITS + 2;  // offset +/- radius width
  localparam int unsigned TB = tmcr_pkg::TILE_BITS;
  localparam logic signed [PW-1:0] TileLast = PW'(tmcr_pkg::TILE_SIDE - 1);

  logic                         valid_q, valid_d;
  logic signed [COORD_BITS-1:0] cx_q, cy_q, tx_q, ty_q;
  logic        [COORD_BITS-2:0] r_q;

  logic                  accept;
  logic signed [RW-1:0]  rx, ry;
  logic signed [PW-1:0]  rxw, ryw, rw;
  logic                  overlap;

  assign busy_o = valid_q && full_i;
  assign accept = start_i && !busy_o;
  assign push_o = valid_q && !full_i;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cx_q <= center_x_i;
      cy_q <= center_y_i;
      r_q  <= radius_i;
      tx_q <= tile_x_i;
      ty_q <= tile_y_i;
    end
  end

  // Center relative to the tile origin; the back end only adds +/-a, +/-b.
  assign rx  = RW'(cx_q) - RW'(tx_q);
  assign ry  = RW'(cy_q) - RW'(ty_q);
  assign rxw = PW'(rx);
  assign ryw = PW'(ry);
  assign rw  = signed'(PW'(r_q));

  // Box [c-r, c+r] meets [t, t+7] on both axes.
  assign overlap = (rxw + rw >= 0) && (rxw - rw <= TileLast) &&
                   (ryw + rw >= 0) && (ryw - rw <= TileLast);

  assign entry_o = {overlap, r_q, ty_q[TB-1:0], tx_q[TB-1:0], ry, rx};

endmodule

/* src/tmcr_queue.sv */
// Two-entry command queue between front end and back end.
// Depends on tmcr_pkg for the default entry width.
module tmcr_queue #(
  parameter int unsigned ENTRY_W = tmcr_pkg::entry_width(tmcr_pkg::COORD_BITS_DEF)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [ENTRY_W-1:0] entry_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output logic [ENTRY_W-1:0] entry_o
);

  logic [ENTRY_W-1:0] mem_q [2];
  logic               wr_q, wr_d, rd_q, rd_d;
  logic [1:0]         cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = ~wr_q;
    end
    if (pop_i) begin
      rd_d = ~rd_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

/* src/tmcr_back.sv */
// Back end: midpoint circle walk, one octant step and eight plots per cycle.
// Depends on tmcr_pkg; pops commands from tmcr_queue.
module tmcr_back #(
  parameter int unsigned COORD_BITS = tmcr_pkg::COORD_BITS_DEF,
  parameter int unsigned ENTRY_W    = tmcr_pkg::entry_width(COORD_BITS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  logic [ENTRY_W-1:0]          entry_i,
  output logic                        pop_o,
  output logic                        done_o,
  output logic [tmcr_pkg::MASK_W-1:0] pixel_mask_o,
  output logic                        box_overlaps_o
);

  localparam int unsigned RW = COORD_BITS + 1;
  localparam int unsigned PW = COORD_BITS + 2;
  localparam int unsigned DW = COORD_BITS + 3;
  localparam int unsigned TB = tmcr_pkg::TILE_BITS;
  localparam int unsigned MW = tmcr_pkg::MASK_W;
  localparam logic signed [DW-1:0] One   = DW'(1);
  localparam logic signed [DW-1:0] Three = DW'(3);
  localparam logic signed [DW-1:0] Five  = DW'(5);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e                 state_q;
  logic                   done_q;
  logic [MW-1:0]          mask_q, mask_d;
  logic                   ovl_q;
  logic [COORD_BITS-1:0]  a_q, b_q;
  logic signed [DW-1:0]   d_q;
  logic signed [RW-1:0]   rx_q, ry_q;
  logic [TB-1:0]          txl_q, tyl_q;

  // Unpacked queue head.
  logic signed [RW-1:0]   e_rx, e_ry;
  logic [TB-1:0]          e_txl, e_tyl;
  logic [COORD_BITS-2:0]  e_r;
  logic                   e_ovl;

  logic                   step;
  logic signed [PW-1:0]   aw, bw, rxw, ryw;
  logic signed [PW-1:0]   px [8];
  logic signed [PW-1:0]   py [8];
  logic signed [DW-1:0]   ad, bd;

  assign {e_ovl, e_r, e_tyl, e_txl, e_ry, e_rx} = entry_i;

  assign pop_o = (state_q == ST_IDLE) && !empty_i;
  assign step  = (state_q == ST_RUN) && (a_q <= b_q);

  assign aw  = signed'(PW'(a_q));
  assign bw  = signed'(PW'(b_q));
  assign rxw = PW'(rx_q);
  assign ryw = PW'(ry_q);
  assign ad  = signed'(DW'(a_q));
  assign bd  = signed'(DW'(b_q));

  // Eight octant mirrors of (a, b), tile-relative.
  always_comb begin
    px[0] = rxw + aw;  py[0] = ryw + bw;
    px[1] = rxw - aw;  py[1] = ryw + bw;
    px[2] = rxw + aw;  py[2] = ryw - bw;
    px[3] = rxw - aw;  py[3] = ryw - bw;
    px[4] = rxw + bw;  py[4] = ryw + aw;
    px[5] = rxw - bw;  py[5] = ryw + aw;
    px[6] = rxw + bw;  py[6] = ryw - aw;
    px[7] = rxw - bw;  py[7] = ryw - aw;
  end

  // Drop points off the tile; place the rest by their low screen bits.
  always_comb begin
    logic [TB-1:0] bx, by;
    mask_d = mask_q;
    for (int i = 0; i < 8; i++) begin
      bx = txl_q + px[i][TB-1:0];
      by = tyl_q + py[i][TB-1:0];
      if (px[i][PW-1:TB] == '0 && py[i][PW-1:TB] == '0) begin
        mask_d = mask_d | (MW'(1) << {by, bx});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (!step) begin
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_q    <= '0;
      b_q    <= COORD_BITS'(e_r);
      d_q    <= One - signed'(DW'(e_r));
      rx_q   <= e_rx;
      ry_q   <= e_ry;
      txl_q  <= e_txl;
      tyl_q  <= e_tyl;
      ovl_q  <= e_ovl;
      mask_q <= '0;
    end else if (step) begin
      mask_q <= mask_d;
      a_q    <= a_q + 1'b1;
      if (d_q < 0) begin
        d_q <= d_q + (ad <<< 1) + Three;
      end else begin
        d_q <= d_q + ((ad - bd) <<< 1) + Five;
        // Zero radius: hold b at zero so the walk ends after the center.
        if (b_q != '0) begin
          b_q <= b_q - 1'b1;
        end
      end
    end
  end

  assign done_o         = done_q;
  assign pixel_mask_o   = mask_q;
  assign box_overlaps_o = ovl_q;

  // A result follows only the end of a walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == ST_RUN) && $past(a_q > b_q))
    else $error("result without finished walk");

  // The walk leaves a past b by at most two.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> ({1'b0, a_q} <= {1'b0, b_q} + 2'd2))
    else $error("walk overshot the octant");

  // The next command is taken only once the current one is out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !(state_q == ST_RUN))
    else $error("queue popped during walk");

  // Every finished walk returns to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == ST_IDLE)
    else $error("state stuck after result");

endmodule

/* src/tiled_midpoint_circle_raster_top.sv */
// Path from start to done_o: front stage, queue, the octant walk, the exit
//   from the walk, then the output register.
// Request rate is set by the single midpoint stepper in the back end, which
//   takes the next request only after its current walk ends.
// Reset: rst_ni clears the front stage, queue and stepper; done_o stays low.
// done_o pulses one cycle per request; the receiver cannot stall.
module tiled_midpoint_circle_raster_top #(
  parameter int unsigned COORD_BITS = tmcr_pkg::COORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [COORD_BITS-1:0] center_x_i,
  input  logic signed [COORD_BITS-1:0] center_y_i,
  input  logic        [COORD_BITS-2:0] radius_i,
  input  logic signed [COORD_BITS-1:0] tile_x_i,
  input  logic signed [COORD_BITS-1:0] tile_y_i,
  output logic                        done_o,
  output logic [tmcr_pkg::MASK_W-1:0] pixel_mask_o,
  output logic                        box_overlaps_o
);

  localparam int unsigned ENTRY_W = tmcr_pkg::entry_width(COORD_BITS);

  // Front-to-queue and queue-to-back handshake.
  logic               push, full, pop, empty;
  logic [ENTRY_W-1:0] push_entry, head_entry;

  // Accept a request, offset it to the tile, run the box test; hold while
  // the queue is full.
  tmcr_front #(
    .COORD_BITS (COORD_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .radius_i   (radius_i),
    .tile_x_i   (tile_x_i),
    .tile_y_i   (tile_y_i),
    .busy_o     (busy),
    .push_o     (push),
    .entry_o    (push_entry),
    .full_i     (full)
  );

  // Buffer up to two classified requests so the front keeps accepting
  // while the stepper walks.
  tmcr_queue #(
    .ENTRY_W (ENTRY_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .entry_o (head_entry)
  );

  // Walk the octant, mirror eight ways, drop off-tile pixels, and
  // emit the mask with the box flag.
  tmcr_back #(
    .COORD_BITS (COORD_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .entry_i        (head_entry),
    .pop_o          (pop),
    .done_o         (done_o),
    .pixel_mask_o   (pixel_mask_o),
    .box_overlaps_o (box_overlaps_o)
  );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for tiled_midpoint_circle_raster_top: directed and random requests.
// Depends on src/tmcr_pkg.sv and the block's RTL; an in-file scoreboard predicts each mask.
module testbench;

  // Geometry taken from the package; cast the side to int so signed compares stay signed.
  localparam int CW   = tmcr_pkg::COORD_BITS_DEF;
  localparam int SIDE = int'(tmcr_pkg::TILE_SIDE);
  localparam int MW   = tmcr_pkg::MASK_W;

  // One expected outcome of a circle request.
  typedef struct {
    logic [MW-1:0] mask;
    logic          overlap;
  } tile_outcome_t;

  // Scoreboard: predict the outline mask of each accepted request, then match the strobes.
  class circle_mask_board;
    tile_outcome_t expected_tiles[$];
    int            errors;

    function new();
      errors = 0;
    endfunction

    function int outstanding();
      return expected_tiles.size();
    endfunction

    // Set the bit of one outline point if it lands inside the tile.
    function logic [MW-1:0] mark(logic [MW-1:0] m, int px, int py, int tx, int ty);
      logic [31:0] ux;
      logic [31:0] uy;
      ux = px;
      uy = py;
      if (px >= tx && px < tx + SIDE && py >= ty && py < ty + SIDE)
        m[{uy[2:0], ux[2:0]}] = 1'b1;
      return m;
    endfunction

    // Walk one octant of the midpoint circle, mirror each point eight ways, queue the outcome.
    function void note_request(int cx, int cy, int r, int tx, int ty);
      tile_outcome_t o;
      int a;
      int b;
      int d;
      o.mask = '0;
      if (r == 0) begin
        o.mask = mark(o.mask, cx, cy, tx, ty);
      end else begin
        a = 0;
        b = r;
        d = 1 - r;
        while (a <= b) begin
          o.mask = mark(o.mask, cx + a, cy + b, tx, ty);
          o.mask = mark(o.mask, cx - a, cy + b, tx, ty);
          o.mask = mark(o.mask, cx + a, cy - b, tx, ty);
          o.mask = mark(o.mask, cx - a, cy - b, tx, ty);
          o.mask = mark(o.mask, cx + b, cy + a, tx, ty);
          o.mask = mark(o.mask, cx - b, cy + a, tx, ty);
          o.mask = mark(o.mask, cx + b, cy - a, tx, ty);
          o.mask = mark(o.mask, cx - b, cy - a, tx, ty);
          if (d < 0) begin
            d = d + 2 * a + 3;
          end else begin
            d = d + 2 * (a - b) + 5;
            b = b - 1;
          end
          a = a + 1;
        end
      end
      o.overlap = (tx <= cx + r) && (tx + SIDE - 1 >= cx - r) &&
                  (ty <= cy + r) && (ty + SIDE - 1 >= cy - r);
      expected_tiles.push_back(o);
    endfunction

    // Compare one strobed result against the oldest prediction.
    function void check_result(logic [MW-1:0] mask, logic overlap);
      tile_outcome_t o;
      if (expected_tiles.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual mask %h overlap %b",
                 $time, mask, overlap);
        errors++;
        return;
      end
      o = expected_tiles.pop_front();
      if (mask !== o.mask) begin
        $display("%0t: pixel_mask expected %h actual %h", $time, o.mask, mask);
        errors++;
      end
      if (overlap !== o.overlap) begin
        $display("%0t: box_overlaps expected %b actual %b", $time, o.overlap, overlap);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic signed [CW-1:0] center_x;
  logic signed [CW-1:0] center_y;
  logic        [CW-2:0] radius;
  logic signed [CW-1:0] tile_x;
  logic signed [CW-1:0] tile_y;
  logic                 done_o;
  logic [MW-1:0]        pixel_mask_o;
  logic                 box_overlaps_o;

  circle_mask_board board;
  int               idle_pct;

  tiled_midpoint_circle_raster_top #(
    .COORD_BITS(CW)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .center_x_i    (center_x),
    .center_y_i    (center_y),
    .radius_i      (radius),
    .tile_x_i      (tile_x),
    .tile_y_i      (tile_y),
    .done_o        (done_o),
    .pixel_mask_o  (pixel_mask_o),
    .box_overlaps_o(box_overlaps_o)
  );

  // 10 ns clock: low half first, so the first rising edge comes at 5 ns.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Take every strobed result at the rising edge that ends its cycle; the receiver never stalls.
  always @(posedge clk_i) begin
    if (done_o === 1'b1) board.check_result(pixel_mask_o, box_overlaps_o);
  end

  // Present one request at a falling edge, idling first at the current sender rate.
  // Hold start high until a rising edge sees busy low, then note the request as accepted.
  task automatic send_circle(input logic signed [CW-1:0] cx, input logic signed [CW-1:0] cy,
                             input logic [CW-2:0] r, input logic signed [CW-1:0] tx,
                             input logic signed [CW-1:0] ty);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start    = 1'b1;
    center_x = cx;
    center_y = cy;
    radius   = r;
    tile_x   = tx;
    tile_y   = ty;
    do @(posedge clk_i); while (busy !== 1'b0);
    board.note_request(center_x, center_y, radius, tile_x, tile_y);
  endtask

  // Build one random request. Keep most radii small so the run stays short, and place
  // most tiles across the outline so the masks are rarely empty.
  task automatic send_random_circle();
    int cx;
    int cy;
    int r;
    int px;
    int py;
    int off;
    int rise;
    int pick;
    cx   = int'($urandom_range(4095)) - 2048;
    cy   = int'($urandom_range(4095)) - 2048;
    pick = $urandom_range(99);
    if (pick < 70) r = $urandom_range(31);
    else if (pick < 90) r = $urandom_range(300);
    else r = $urandom_range(2047);
    pick = $urandom_range(99);
    if (pick < 60) begin
      // Land the tile on a true outline point in a random quadrant.
      off  = int'($urandom_range(2 * r)) - r;
      rise = $rtoi($sqrt(real'(r * r - off * off)));
      if ($urandom_range(1)) rise = -rise;
      if ($urandom_range(1)) begin
        px = cx + off;
        py = cy + rise;
      end else begin
        px = cx + rise;
        py = cy + off;
      end
      px = px - int'($urandom_range(SIDE - 1));
      py = py - int'($urandom_range(SIDE - 1));
    end else if (pick < 80) begin
      // Cover the center, which matters most for tiny radii.
      px = cx - int'($urandom_range(SIDE - 1));
      py = cy - int'($urandom_range(SIDE - 1));
    end else begin
      px = int'($urandom_range(4095)) - 2048;
      py = int'($urandom_range(4095)) - 2048;
    end
    // Truncate to the port widths; tiles that wrap are still legal requests.
    send_circle(CW'(cx), CW'(cy), (CW-1)'(r), CW'(px), CW'(py));
  endtask

  // Bound the run well above the slowest legal case: every request at full radius.
  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    board    = new();
    idle_pct = 23;
    rst_ni   = 1'b0;
    start    = 1'b0;
    center_x = '0;
    center_y = '0;
    radius   = '0;
    tile_x   = '0;
    tile_y   = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: zero radius in and out of the tile.
    send_circle(3, 5, 0, 0, 0);
    send_circle(8, 0, 0, 0, 0);
    send_circle(-2048, -2048, 0, -2048, -2048);
    send_circle(2047, 2047, 0, 2040, 2040);
    // Tiny circles, the smaller ones fully inside one tile, seams between octants included.
    send_circle(3, 3, 1, 0, 0);
    send_circle(4, 4, 3, 0, 0);
    send_circle(0, 0, 7, 0, 0);
    send_circle(0, 0, 8, -8, -8);
    // Full radius, reaching past both ends of the screen range.
    send_circle(0, 0, 2047, 2040, -4);
    send_circle(0, 0, 2047, -2048, -4);
    send_circle(-2048, -2048, 2047, -2048, -2048);
    send_circle(2047, 2047, 2047, 2040, 2040);
    // Tiles off the 8-pixel grid, positive and negative.
    send_circle(10, 10, 5, 13, 3);
    send_circle(-5, -7, 6, -3, -14);
    // Box test edges: far away, corner touch, one-pixel miss, tile enclosed by circle.
    send_circle(100, 100, 5, -200, -200);
    send_circle(0, 0, 4, 4, 4);
    send_circle(0, 0, 4, 5, -3);
    send_circle(0, 0, 100, -4, -4);
    // Single set bits and extremes on each field.
    send_circle(2047, -2048, 1023, -1, 0);
    send_circle(-2048, 2047, 1024, -1024, 2040);
    send_circle(-1, -1, 1, -8, -8);

    // Random part in three rates: light idling, heavy idling, then back to back.
    repeat (137) send_random_circle();
    idle_pct = 67;
    repeat (137) send_random_circle();
    idle_pct = 0;
    repeat (136) send_random_circle();
    @(negedge clk_i);
    start = 1'b0;

    // Drain, then leave room for any stray strobe.
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (32) @(posedge clk_i);
    if (board.outstanding() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, board.outstanding());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
